@@ hw/rtl/core_count_hotplug_governor_core_assert.svh @@
// Assertion macros shared by the core count governor RTL.
// Included by every module that carries concurrent assertions.
`ifndef CORE_COUNT_HOTPLUG_GOVERNOR_CORE_ASSERT_SVH
`define CORE_COUNT_HOTPLUG_GOVERNOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CCGOV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccgov assertion failed");
// Next-cycle implication.
`define CCGOV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccgov assertion failed");
`else
`define CCGOV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CCGOV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/ccgov_pkg.sv @@
// Types, constants and the threshold ladder table of the core count governor.
// No dependencies; used by every module of the block.
package ccgov_pkg;

  // Core count and load format
  localparam int CORES     = 4;
  localparam int FRAC_BITS = 11;
  localparam int CNT_W     = 3;
  localparam int LOAD_W    = 20;
  localparam int TIME_W    = 48;
  localparam int HOLD_W    = 32;
  localparam int MODE_W    = 2;
  localparam int ACT_W     = 2;
  localparam int IDX_W     = 3;
  localparam int CFG_DW    = 32;

  // Threshold arithmetic: thread capacity less a margin, scaled by num/den
  localparam int CAP_MARGIN    = 50;
  localparam int THREAD_CAP    = 339 - CAP_MARGIN;
  localparam int THR_SCALE_NUM = 4;
  localparam int THR_SCALE_DEN = 100000;
  localparam int THR_380  = (THREAD_CAP * 380  * THR_SCALE_NUM) / THR_SCALE_DEN;
  localparam int THR_625  = (THREAD_CAP * 625  * THR_SCALE_NUM) / THR_SCALE_DEN;
  localparam int THR_875  = (THREAD_CAP * 875  * THR_SCALE_NUM) / THR_SCALE_DEN;
  localparam int THR_1125 = (THREAD_CAP * 1125 * THR_SCALE_NUM) / THR_SCALE_DEN;
  localparam int THR_1625 = (THREAD_CAP * 1625 * THR_SCALE_NUM) / THR_SCALE_DEN;
  localparam int THR_2125 = (THREAD_CAP * 2125 * THR_SCALE_NUM) / THR_SCALE_DEN;
  localparam int THR_W    = 5;
  localparam int HYS_W    = THR_W + 1;
  localparam int SH_W     = 5;
  localparam int CMP_W    = LOAD_W + HYS_W;
  localparam int QUAD     = 4;
  localparam int TRI      = 3;
  localparam int DUO      = 2;

  // Boost rate limit in microseconds
  localparam int BOOST_MIN_GAP_US = 150 * 1000;
  localparam int HOLD_RESET       = 2500000;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_INPUT = 1'b1
  } cmd_e_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE  = 2'd0,
    ACT_RAISE = 2'd1,
    ACT_LOWER = 2'd2,
    ACT_HELD  = 2'd3
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_BALANCE = 2'd0,
    MODE_PERF    = 2'd1,
    MODE_CONSERV = 2'd2,
    MODE_OFF     = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MAX_CORES   = 3'd0,
    REG_MIN_CORES   = 3'd1,
    REG_PROFILE     = 3'd2,
    REG_BOOST_CORES = 3'd3,
    REG_BOOST_HOLD  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  max_cores;
    logic [CNT_W-1:0]  min_cores;
    mode_t             profile_mode;
    logic [CNT_W-1:0]  boost_cores;
    logic [HOLD_W-1:0] boost_hold_us;
  } cfg_t;

  // Threshold in whole tasks of ladder step idx for the given limit and mode
  function automatic logic [THR_W-1:0] ladder_thr(input logic [CNT_W-1:0] maxc,
                                                  input mode_t mode,
                                                  input logic [1:0] idx);
    logic [THR_W-1:0] thr;
    thr = '0;
    if (maxc >= CNT_W'(QUAD)) begin
      unique case (mode)
        MODE_BALANCE: begin
          case (idx)
            2'd0:    thr = THR_W'(THR_625);
            2'd1:    thr = THR_W'(THR_875);
            default: thr = THR_W'(THR_1125);
          endcase
        end
        MODE_PERF: begin
          case (idx)
            2'd0:    thr = THR_W'(THR_380);
            2'd1:    thr = THR_W'(THR_625);
            default: thr = THR_W'(THR_875);
          endcase
        end
        MODE_CONSERV: begin
          case (idx)
            2'd0:    thr = THR_W'(THR_875);
            2'd1:    thr = THR_W'(THR_1625);
            default: thr = THR_W'(THR_2125);
          endcase
        end
        default: thr = '0;
      endcase
    end else if (maxc == CNT_W'(TRI)) begin
      thr = (idx == 2'd0) ? THR_W'(THR_625) : THR_W'(THR_875);
    end else if (maxc == CNT_W'(DUO)) begin
      thr = THR_W'(THR_380);
    end
    return thr;
  endfunction

endpackage

@@ hw/rtl/ccgov_cfg.sv @@
// Configuration registers of the core count governor with limit checking.
// Depends on ccgov_pkg and the assertion macro header.
`include "core_count_hotplug_governor_core_assert.svh"

module ccgov_cfg
  import ccgov_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg_o
);

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic [CNT_W-1:0] wval;
  logic             wval_ok;

  // Limit writes outside 1..CORES are dropped
  assign wval    = cfg_wdata[CNT_W-1:0];
  assign wval_ok = (wval >= CNT_W'(1)) && (wval <= CNT_W'(CORES));

  // Decode the write; crossing limits drag the other limit along
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_CORES: begin
          if (wval_ok) begin
            if (cfg_r.min_cores > wval) cfg_nxt.min_cores = wval;
            cfg_nxt.max_cores = wval;
          end
        end
        REG_MIN_CORES: begin
          if (wval_ok) begin
            if (cfg_r.max_cores < wval) cfg_nxt.max_cores = wval;
            cfg_nxt.min_cores = wval;
          end
        end
        REG_PROFILE:     cfg_nxt.profile_mode  = mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_BOOST_CORES: cfg_nxt.boost_cores   = cfg_wdata[CNT_W-1:0];
        REG_BOOST_HOLD:  cfg_nxt.boost_hold_us = cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_cores     <= CNT_W'(CORES);
      cfg_r.min_cores     <= CNT_W'(1);
      cfg_r.profile_mode  <= MODE_BALANCE;
      cfg_r.boost_cores   <= CNT_W'(1);
      cfg_r.boost_hold_us <= HOLD_W'(HOLD_RESET);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

  `CCGOV_ASSERT_IMP(a_cfg_order, clk, rst_n, 1'b1, cfg_r.min_cores <= cfg_r.max_cores)
  `CCGOV_ASSERT_IMP(a_cfg_max_rng, clk, rst_n, 1'b1, (cfg_r.max_cores >= CNT_W'(1)) && (cfg_r.max_cores <= CNT_W'(CORES)))

endmodule

@@ hw/rtl/ccgov_ladder.sv @@
// Threshold ladder walk: turns a load sample into a wanted core count.
// Depends on ccgov_pkg (ladder table, widths, config struct).
module ccgov_ladder
  import ccgov_pkg::*;
(
  input  cfg_t              cfg_i,
  input  logic [CNT_W-1:0]  last_count,
  input  logic [LOAD_W-1:0] avg_load,
  output logic [CNT_W-1:0]  count
);

  logic [SH_W-1:0]  shift;
  logic [CMP_W-1:0] load_ext;

  // Thresholds are scaled to FRAC_BITS less (max_cores - 1) fraction bits
  assign shift    = SH_W'(FRAC_BITS + 1) - SH_W'(cfg_i.max_cores);
  assign load_ext = CMP_W'(avg_load);

  // Compare every step in parallel, stop at the first one not exceeded
  always_comb begin
    logic [CNT_W-1:0] n;
    logic             stop;
    logic [CNT_W-1:0] stepn;
    logic [HYS_W-1:0] thr_h;
    logic [CMP_W-1:0] thr_s;
    n    = CNT_W'(1);
    stop = 1'b0;
    for (int i = 0; i < CORES - 1; i++) begin
      stepn = CNT_W'(i + 1);
      thr_h = HYS_W'(ladder_thr(cfg_i.max_cores, cfg_i.profile_mode, 2'(i)));
      // Hysteresis while the step is at or above the last result
      if (last_count <= stepn) thr_h = thr_h + HYS_W'({cfg_i.max_cores, 1'b0});
      thr_s = CMP_W'(thr_h) << shift;
      if (!stop) begin
        if ((stepn < cfg_i.max_cores) && (load_ext > thr_s)) n = n + CNT_W'(1);
        else stop = 1'b1;
      end
    end
    count = n;
  end

endmodule

@@ hw/rtl/core_count_hotplug_governor_core.sv @@
// Top level of the core count governor: input register, decision logic,
// result register and history state. Uses ccgov_pkg, ccgov_cfg, ccgov_ladder.
//
//  channel | ports                            | payload
//  --------+----------------------------------+-----------------------------------
//  in      | in_tvalid/in_tready/in_tdata/    | avg_load, now_us, online_cores;
//          | in_tuser                         | tuser = cmd
//  out     | out_tvalid/out_tready/out_tdata  | target_cores, action
//  cfg     | cfg_we/cfg_index/cfg_wdata       | one register write per cycle
//
// One item per cycle sustained while out_tready stays high. An item is held in the
// input register while the ladder compare, clamp and 48-bit time checks run, and the
// result register then presents it. Reset (rst_n low at a clock edge) empties both
// registers and clears the count and time history.
// A low out_tready holds the result register, then the input register, and
// in_tready drops only when both are full.
`include "core_count_hotplug_governor_core_assert.svh"

module core_count_hotplug_governor_core
  import ccgov_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [71:0]       in_tdata,   // [19:0] avg_load, [67:20] now_us,
                                        // [70:68] online_cores, [71] zero
  input  logic              in_tuser,   // [0] cmd
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [2:0] target_cores, [4:3] action,
                                        // [7:5] zero
  // configuration port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t              cfg;

  logic              s1_valid_r;
  cmd_e_t            s1_cmd_r;
  logic [LOAD_W-1:0] s1_load_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [CNT_W-1:0]  s1_online_r;

  logic              out_valid_r;
  logic [CNT_W-1:0]  out_tgt_r;
  action_t           out_act_r;

  logic [CNT_W-1:0]  last_count_r;
  logic [TIME_W-1:0] last_input_time_r;
  logic [TIME_W-1:0] last_boost_time_r;

  logic              advance;
  logic              in_xfer;
  logic              s1_fire;

  logic [CNT_W-1:0]  count_c;
  logic              boost_en;
  logic              boost_ok;
  logic [TIME_W-1:0] since_boost;
  logic [TIME_W-1:0] since_input;
  logic              recent_input;
  logic [CNT_W-1:0]  want;
  logic [CNT_W-1:0]  clamped;
  logic [CNT_W-1:0]  tgt_c;
  action_t           act_c;

  ccgov_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  ccgov_ladder u_ladder (
    .cfg_i      (cfg),
    .last_count (last_count_r),
    .avg_load   (s1_load_r),
    .count      (count_c)
  );

  // Handshake: each register moves when the one after it can take
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;
  assign s1_fire   = s1_valid_r && advance;

  // Boost eligibility: enabled, rate limited, and actually adds cores
  assign boost_en    = cfg.boost_cores != CNT_W'(1);
  assign since_boost = s1_now_r - last_boost_time_r;
  assign boost_ok    = boost_en && (since_boost >= TIME_W'(BOOST_MIN_GAP_US)) &&
                       (s1_online_r < cfg.boost_cores) &&
                       (cfg.boost_cores > cfg.min_cores);

  // An input event has just refreshed the input time, so its age is zero
  assign since_input  = s1_now_r - last_input_time_r;
  assign recent_input = (s1_cmd_r == CMD_INPUT) ? (cfg.boost_hold_us != '0)
                                                : (since_input < TIME_W'(cfg.boost_hold_us));

  // Clamp the request to the limits
  assign want    = (s1_cmd_r == CMD_INPUT) ? cfg.boost_cores : count_c;
  assign clamped = (want < cfg.min_cores) ? cfg.min_cores :
                   (want > cfg.max_cores) ? cfg.max_cores : want;

  // Compare with the online count to pick the action
  always_comb begin
    tgt_c = clamped;
    act_c = ACT_NONE;
    if ((s1_cmd_r == CMD_INPUT) && !boost_ok) begin
      tgt_c = s1_online_r;
    end else if (clamped < s1_online_r) begin
      act_c = ((s1_online_r <= cfg.boost_cores) && recent_input) ? ACT_HELD : ACT_LOWER;
    end else if (clamped > s1_online_r) begin
      act_c = ACT_RAISE;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r    <= cmd_e_t'(in_tuser);
      s1_load_r   <= in_tdata[LOAD_W-1:0];
      s1_now_r    <= in_tdata[LOAD_W+TIME_W-1:LOAD_W];
      s1_online_r <= in_tdata[LOAD_W+TIME_W+CNT_W-1:LOAD_W+TIME_W];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_tgt_r <= tgt_c;
      out_act_r <= act_c;
    end
  end

  // History: last ladder result and the input and boost times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r      <= '0;
      last_input_time_r <= '0;
      last_boost_time_r <= '0;
    end else if (s1_fire) begin
      if (s1_cmd_r == CMD_LOAD) begin
        last_count_r <= count_c;
      end else if (boost_en) begin
        last_input_time_r <= s1_now_r;
        if (boost_ok) last_boost_time_r <= s1_now_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_act_r, out_tgt_r};

  `CCGOV_ASSERT_IMP(a_count_rng, clk, rst_n, s1_valid_r, (count_c >= CNT_W'(1)) && (count_c <= cfg.max_cores))
  `CCGOV_ASSERT_IMP(a_tgt_in_lim, clk, rst_n, s1_valid_r && (act_c != ACT_NONE), (tgt_c >= cfg.min_cores) && (tgt_c <= cfg.max_cores))
  `CCGOV_ASSERT_IMP(a_held_lowers, clk, rst_n, s1_valid_r && (act_c == ACT_HELD), tgt_c < s1_online_r)
  `CCGOV_ASSERT_NXT(a_fire_to_out, clk, rst_n, s1_fire, out_valid_r)

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for core_count_hotplug_governor_core.
// Depends on ccgov_pkg and the block's RTL. A scoreboard class predicts each
// transfer; plain tasks drive the input stream and the register port.
`timescale 1ns / 1ps

module tb;
  import ccgov_pkg::*;

  // Ladder arithmetic: thread capacity less the reserve, scaled by 4/100000
  localparam int TASK_CAP      = 339 - 50;
  localparam int BOOST_GAP_US  = 150 * 1000;
  localparam int ITEMS_PER_SET = 160;
  localparam int NUM_SETS      = 12;

  // Predicts the core count decision and keeps the results still owed
  class hotplug_scoreboard;
    typedef struct packed {
      logic [CNT_W-1:0] target;
      action_t          act;
    } verdict_t;

    logic [CNT_W-1:0]  lim_max;
    logic [CNT_W-1:0]  lim_min;
    mode_t             mode;
    logic [CNT_W-1:0]  boost_n;
    logic [HOLD_W-1:0] hold_us;
    logic [CNT_W-1:0]  prev_count;
    logic [TIME_W-1:0] input_stamp;
    logic [TIME_W-1:0] boost_stamp;
    verdict_t          owed[$];
    int                fails;

    function new();
      lim_max     = CNT_W'(CORES);
      lim_min     = 3'd1;
      mode        = MODE_BALANCE;
      boost_n     = 3'd1;
      hold_us     = 32'd2500000;
      prev_count  = '0;
      input_stamp = '0;
      boost_stamp = '0;
      fails       = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply a register write, with the limit range and crossing rules
    function void configure(cfg_reg_t idx, logic [CFG_DW-1:0] data);
      logic [CNT_W-1:0] v;
      v = data[CNT_W-1:0];
      case (idx)
        REG_MAX_CORES: begin
          if (v >= 1 && v <= CORES) begin
            if (lim_min > v) lim_min = v;
            lim_max = v;
          end
        end
        REG_MIN_CORES: begin
          if (v >= 1 && v <= CORES) begin
            if (lim_max < v) lim_max = v;
            lim_min = v;
          end
        end
        REG_PROFILE:     mode = mode_t'(data[MODE_W-1:0]);
        REG_BOOST_CORES: boost_n = v;
        REG_BOOST_HOLD:  hold_us = data;
        default: ;
      endcase
    endfunction

    // Threshold in whole tasks of one step of the ladder
    function int rung(int maxc, int idx);
      int pm;
      if (maxc >= 4) begin
        case (mode)
          MODE_BALANCE: pm = (idx == 0) ? 625 : (idx == 1) ? 875 : 1125;
          MODE_PERF:    pm = (idx == 0) ? 380 : (idx == 1) ? 625 : 875;
          MODE_CONSERV: pm = (idx == 0) ? 875 : (idx == 1) ? 1625 : 2125;
          default:      return 0;
        endcase
      end else if (maxc == 3) begin
        pm = (idx == 0) ? 625 : 875;
      end else begin
        pm = 380;
      end
      return (TASK_CAP * pm * 4) / 100000;
    endfunction

    // Walk the ladder until the load fits under a step
    function int count_for_load(logic [LOAD_W-1:0] load);
      int maxc;
      int shift;
      int thr;
      int n;
      maxc = int'(lim_max);
      if (maxc < 1) maxc = 1;
      if (maxc > CORES) maxc = CORES;
      shift = FRAC_BITS - (maxc - 1);
      for (n = 1; n < maxc; n++) begin
        thr = rung(maxc, n - 1);
        // hysteresis on steps at or above the last decision
        if (prev_count <= n) thr = thr + 2 * maxc;
        if (longint'(load) <= (longint'(thr) << shift)) break;
      end
      prev_count = n[CNT_W-1:0];
      return n;
    endfunction

    // Clamp to the limits and compare with the online count
    function verdict_t settle(int want, logic [CNT_W-1:0] online,
                              logic [TIME_W-1:0] now);
      verdict_t          v;
      int                tgt;
      logic [TIME_W-1:0] age;
      tgt = want;
      if (tgt < int'(lim_min)) tgt = int'(lim_min);
      else if (tgt > int'(lim_max)) tgt = int'(lim_max);
      age   = now - input_stamp;
      v.act = ACT_NONE;
      if (tgt < int'(online)) begin
        if (online <= boost_n && age < TIME_W'(hold_us)) v.act = ACT_HELD;
        else v.act = ACT_LOWER;
      end else if (tgt > int'(online)) begin
        v.act = ACT_RAISE;
      end
      v.target = tgt[CNT_W-1:0];
      return v;
    endfunction

    // Predict the result of one accepted input transfer
    function void note(logic cmd, logic [71:0] tdata);
      logic [LOAD_W-1:0] load;
      logic [TIME_W-1:0] now;
      logic [CNT_W-1:0]  online;
      logic [TIME_W-1:0] since_boost;
      verdict_t          v;
      load   = tdata[19:0];
      now    = tdata[67:20];
      online = tdata[70:68];
      if (cmd == CMD_LOAD) begin
        v = settle(count_for_load(load), online, now);
      end else begin
        v.target = online;
        v.act    = ACT_NONE;
        if (boost_n != 3'd1) begin
          input_stamp = now;
          since_boost = now - boost_stamp;
          // boost only past the rate limit and when it would add cores
          if (since_boost >= TIME_W'(BOOST_GAP_US) && online < boost_n &&
              boost_n > lim_min) begin
            v           = settle(boost_n, online, now);
            boost_stamp = now;
          end
        end
      end
      owed.push_back(v);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check(logic [7:0] tdata);
      verdict_t v;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual target %0d action %0d",
                 $time, tdata[2:0], tdata[4:3]);
        fails++;
        return;
      end
      v = owed.pop_front();
      if (tdata[2:0] !== v.target) begin
        $display("%0t: target_cores mismatch, expected %0d, actual %0d",
                 $time, v.target, tdata[2:0]);
        fails++;
      end
      if (tdata[4:3] !== v.act) begin
        $display("%0t: action mismatch, expected %0d, actual %0d",
                 $time, v.act, tdata[4:3]);
        fails++;
      end
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [71:0]       in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              cfg_we     = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  logic              idle_off   = 1'b0;
  logic [TIME_W-1:0] clock_us   = '0;
  int                ladder_marks[6] = '{4, 7, 10, 13, 18, 24};
  hotplug_scoreboard sb;

  core_count_hotplug_governor_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side at random, except in the no-idle stretch
  always @(posedge clk) begin
    out_tready <= idle_off ? 1'b1 : ($urandom_range(0, 99) >= 34);
  end

  // Record every transfer on both streams
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check(out_tdata);
      if (in_tvalid && in_tready) sb.note(in_tuser, in_tdata);
    end
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input logic cmd, input logic [LOAD_W-1:0] load,
                           input logic [TIME_W-1:0] now,
                           input logic [CNT_W-1:0] online);
    while (!idle_off && $urandom_range(0, 99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, online, now, load};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.configure(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0]  mx;
    logic [CNT_W-1:0]  mn;
    logic [CNT_W-1:0]  bc;
    mode_t             md;
    logic [HOLD_W-1:0] hd;
    logic [LOAD_W-1:0] load;
    int                r;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: load extremes, ladder edges, input without boost
    send_item(CMD_LOAD, 20'd0, 48'd0, 3'd4);
    send_item(CMD_LOAD, 20'hFFFFF, 48'd10, 3'd1);
    send_item(CMD_LOAD, 20'd1792, 48'd20, 3'd2);
    send_item(CMD_LOAD, 20'd3841, 48'd30, 3'd2);
    send_item(CMD_LOAD, 20'd4608, 48'd40, 3'd3);
    send_item(CMD_INPUT, 20'd5, 48'd50, 3'd1);

    // Boosting on: rate limit, boost issued, already online, hold window
    drain();
    write_reg(REG_BOOST_CORES, 32'd3);
    write_reg(REG_PROFILE, 32'(MODE_PERF));
    send_item(CMD_INPUT, 20'd0, 48'd100000, 3'd1);
    send_item(CMD_INPUT, 20'd0, 48'd300000, 3'd1);
    send_item(CMD_INPUT, 20'd0, 48'd350000, 3'd1);
    send_item(CMD_INPUT, 20'd0, 48'd700000, 3'd3);
    send_item(CMD_LOAD, 20'd0, 48'd800000, 3'd3);
    send_item(CMD_LOAD, 20'd0, 48'd800000, 3'd4);
    send_item(CMD_LOAD, 20'd0, 48'd3200000, 3'd3);

    // Boost count not above the floor only stamps the input time
    drain();
    write_reg(REG_MIN_CORES, 32'd3);
    send_item(CMD_INPUT, 20'd0, 48'd4000000, 3'd1);

    // Crossing limits, ignored out-of-range limits, disabled thresholds
    drain();
    write_reg(REG_MAX_CORES, 32'd2);
    write_reg(REG_MAX_CORES, 32'd0);
    write_reg(REG_MAX_CORES, 32'd7);
    write_reg(REG_MIN_CORES, 32'd5);
    send_item(CMD_LOAD, 20'd4096, 48'd4100000, 3'd1);
    drain();
    write_reg(REG_MAX_CORES, 32'd4);
    write_reg(REG_PROFILE, 32'(MODE_OFF));
    send_item(CMD_LOAD, 20'd0, 48'd4200000, 3'd1);
    send_item(CMD_LOAD, 20'hFFFFF, 48'd4300000, 3'd4);

    // Time wrap-around on the rate limit and the hold window
    drain();
    write_reg(REG_MIN_CORES, 32'd1);
    write_reg(REG_BOOST_CORES, 32'd4);
    write_reg(REG_BOOST_HOLD, 32'hFFFF_FFFF);
    send_item(CMD_INPUT, 20'd0, 48'hFFFF_FFFF_FFF0, 3'd1);
    send_item(CMD_INPUT, 20'd0, 48'd16, 3'd1);
    send_item(CMD_LOAD, 20'd0, 48'd100, 3'd4);

    // Single and three-core ladders
    drain();
    write_reg(REG_MAX_CORES, 32'd1);
    send_item(CMD_LOAD, 20'hFFFFF, 48'd200, 3'd2);
    drain();
    write_reg(REG_MAX_CORES, 32'd3);
    send_item(CMD_LOAD, 20'd3584, 48'd300, 3'd3);
    send_item(CMD_LOAD, 20'd8193, 48'd400, 3'd2);

    // Random sets: settings change only while the block is empty
    for (int set_no = 0; set_no < NUM_SETS; set_no++) begin
      drain();
      case (set_no)
        0: begin mx = 3'd1; mn = 3'd1; md = MODE_BALANCE; bc = 3'd1; hd = 32'd0; end
        1: begin mx = 3'd4; mn = 3'd4; md = MODE_OFF; bc = 3'd4; hd = 32'hFFFF_FFFF; end
        2: begin mx = 3'd4; mn = 3'd1; md = MODE_CONSERV; bc = 3'd4; hd = 32'd2500000; end
        3: begin mx = 3'd2; mn = 3'd1; md = MODE_PERF; bc = 3'd2; hd = 32'd1000000; end
        default: begin
          mx = 3'($urandom_range(1, 4));
          mn = 3'($urandom_range(1, 4));
          md = mode_t'($urandom_range(0, 3));
          bc = ($urandom_range(0, 5) == 0) ? 3'd1 : 3'($urandom_range(2, 4));
          case ($urandom_range(0, 4))
            0:       hd = 32'd0;
            1:       hd = 32'hFFFF_FFFF;
            2:       hd = 32'd2500000;
            3:       hd = $urandom_range(0, 3000000);
            default: hd = $urandom;
          endcase
        end
      endcase
      // upper write bits are junk the block must ignore
      if ($urandom_range(0, 1)) begin
        write_reg(REG_MAX_CORES, ($urandom & 32'hFFFF_FFF8) | mx);
        write_reg(REG_MIN_CORES, ($urandom & 32'hFFFF_FFF8) | mn);
      end else begin
        write_reg(REG_MIN_CORES, ($urandom & 32'hFFFF_FFF8) | mn);
        write_reg(REG_MAX_CORES, ($urandom & 32'hFFFF_FFF8) | mx);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_MAX_CORES : REG_MIN_CORES,
                  ($urandom & 32'hFFFF_FFF8) | ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 7)));
      write_reg(REG_PROFILE, ($urandom & 32'hFFFF_FFFC) | md);
      write_reg(REG_BOOST_CORES, ($urandom & 32'hFFFF_FFF8) | bc);
      write_reg(REG_BOOST_HOLD, hd);
      idle_off = (set_no == 2);

      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        // advance the time base, now and then jumping anywhere
        r = $urandom_range(0, 99);
        if (r < 55) clock_us = clock_us + $urandom_range(0, 200000);
        else if (r < 85) clock_us = clock_us + $urandom_range(0, 3000000);
        else if (r < 95) clock_us = clock_us + $urandom;
        else clock_us = 48'({$urandom, $urandom});
        // loads cluster around the scaled ladder steps
        r = $urandom_range(0, 99);
        if (r < 45) load = 20'($urandom_range(0, 9000));
        else if (r < 75)
          load = 20'(((ladder_marks[$urandom_range(0, 5)] + 2 * $urandom_range(0, 4))
                      << $urandom_range(8, 11)) + $urandom_range(0, 2) - 1);
        else load = 20'($urandom);
        send_item(($urandom_range(0, 99) < 70) ? CMD_LOAD : CMD_INPUT, load, clock_us,
                  3'($urandom_range(1, 4)));
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    idle_off = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ccgov_pkg.sv
hw/rtl/ccgov_cfg.sv
hw/rtl/ccgov_ladder.sv
hw/rtl/core_count_hotplug_governor_core.sv
verif/tb.sv
